FILE: sv/assert_macros.svh
// Assertion macros used by the port-level checker of the frame deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/scfd_pkg.sv
// Package: constants and types of the sync checksum frame deframer.
`timescale 1ns / 1ps
package scfd_pkg;

    // Window geometry: 19 held bytes plus the incoming byte form a frame.
    localparam int unsigned WIN_LEN   = 20;
    localparam int unsigned HELD_LEN  = WIN_LEN - 1;
    localparam int unsigned FILL_W    = 5;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 4'd0,
        REG_SYNC_SECOND = 4'd1
    } cfg_reg_t;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

    // Status from the frame detector to the output stage.
    typedef struct packed {
        logic full;
        logic hit;
    } det_t;

endpackage

FILE: sv/scfd_cell.sv
// One byte cell of the receive shift line.
`timescale 1ns / 1ps
module scfd_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte on every transaction
    always_comb begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

FILE: sv/scfd_detect.sv
// Frame detector: fill count, running checksum and sync/checksum compare.
`timescale 1ns / 1ps
module scfd_detect (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        byte0,
    input  logic [7:0]        byte1,
    input  logic [7:0]        byte2,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    output scfd_pkg::det_t    det
);

    localparam logic [scfd_pkg::FILL_W-1:0] FILL_FULL =
        scfd_pkg::FILL_W'(scfd_pkg::HELD_LEN);

    logic [scfd_pkg::FILL_W-1:0] fill_reg;
    logic [scfd_pkg::FILL_W-1:0] fill_next;
    logic [7:0]                  sum_reg;
    logic [7:0]                  sum_next;

    // Compare the candidate frame: held bytes plus the incoming one
    always_comb begin
        det.full = (fill_reg == FILL_FULL);
        det.hit  = det.full && (byte0 == sync_first) && (byte1 == sync_second)
                   && (rx_byte == sum_reg);
    end

    // Advance fill count; the sum tracks cells 2..18 of the shift line
    always_comb begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (advance) begin
            sum_next = sum_reg - byte2 + rx_byte;
            if (det.hit) begin
                fill_next = '0;
            end else if (det.full) begin
                fill_next = FILL_FULL;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

FILE: sv/sync_checksum_frame_deframer.sv
// Top level of the sync checksum frame deframer.
// Usage:
//   Input channel s_*: one received serial byte per transaction (s_rx_byte).
//   Result channel m_*: one result per input byte. m_frame_found is 1 when
//   that byte completed a frame (two sync bytes, 17 summed bytes, checksum);
//   the frame fields are then valid, otherwise they are all zero.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 = first sync byte, 1 = second sync byte); other indexes are ignored.
// Output: each result is registered and shown in the cycle after its transaction.
// Throughput: one byte per cycle while s_ready is high; the shift line of 19
//   byte cells and the running checksum both advance once per transaction.
// Stall: while a result waits on m_ready, s_ready stays high only if the
//   output register is taken in the same cycle; otherwise input is held off.
// Reset: sync bytes return to 0x55 / 0xAA, the window empties, no result is
//   pending.
`timescale 1ns / 1ps
module sync_checksum_frame_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_frame_found,
    output logic [7:0]                         m_length_byte,
    output logic [31:0]                        m_frame_count,
    output logic [63:0]                        m_payload_low,
    output logic [31:0]                        m_payload_high,
    output logic [7:0]                         m_checksum_byte,
    input  logic                               cfg_we,
    input  logic [scfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int unsigned HELD = scfd_pkg::HELD_LEN;

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       found_reg;
    logic [7:0] length_reg;
    logic [31:0] count_reg;
    logic [63:0] pay_lo_reg;
    logic [31:0] pay_hi_reg;
    logic [7:0] csum_reg;

    logic       take;
    logic [7:0] win_q [HELD];
    scfd_pkg::det_t det;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= scfd_pkg::SYNC_FIRST_RST;
            sync_second_reg <= scfd_pkg::SYNC_SECOND_RST;
        end else if (cfg_we) begin
            if (cfg_index == scfd_pkg::REG_SYNC_FIRST) begin
                sync_first_reg <= cfg_wdata[7:0];
            end else if (cfg_index == scfd_pkg::REG_SYNC_SECOND) begin
                sync_second_reg <= cfg_wdata[7:0];
            end
        end
    end

    // Shift line: newest byte enters the top cell, cell 0 holds the oldest
    for (genvar i = 0; i < HELD; i++) begin : g_cell
        if (i == HELD - 1) begin : g_top
            scfd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (take),
                .d_in     (s_rx_byte),
                .q        (win_q[i])
            );
        end else begin : g_mid
            scfd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (take),
                .d_in     (win_q[i+1]),
                .q        (win_q[i])
            );
        end
    end

    scfd_detect u_detect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (take),
        .rx_byte     (s_rx_byte),
        .byte0       (win_q[0]),
        .byte1       (win_q[1]),
        .byte2       (win_q[2]),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .det         (det)
    );

    // Output valid: set on a transaction, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload: frame fields on a hit, zeros otherwise
    always_ff @(posedge aclk) begin
        if (take) begin
            found_reg <= det.hit;
            if (det.hit) begin
                length_reg <= win_q[2];
                for (int k = 0; k < 4; k++) begin
                    count_reg[8*k +: 8]  <= win_q[3 + k];
                    pay_hi_reg[8*k +: 8] <= win_q[15 + k];
                end
                for (int k = 0; k < 8; k++) begin
                    pay_lo_reg[8*k +: 8] <= win_q[7 + k];
                end
                csum_reg <= s_rx_byte;
            end else begin
                length_reg <= '0;
                count_reg  <= '0;
                pay_lo_reg <= '0;
                pay_hi_reg <= '0;
                csum_reg   <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_found   = found_reg;
    assign m_length_byte   = length_reg;
    assign m_frame_count   = count_reg;
    assign m_payload_low   = pay_lo_reg;
    assign m_payload_high  = pay_hi_reg;
    assign m_checksum_byte = csum_reg;

endmodule

FILE: sv/scfd_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scfd_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_frame_found,
    input  logic [7:0]                         m_length_byte,
    input  logic [31:0]                        m_frame_count,
    input  logic [63:0]                        m_payload_low,
    input  logic [31:0]                        m_payload_high,
    input  logic [7:0]                         m_checksum_byte
);

    // Hold a stalled result
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_frame_found) && $stable(m_payload_low))

    // Every transaction produces a result next cycle
    `ASSERT_NXT(a_in_to_out, aclk, aresetn, s_valid && s_ready, m_valid)

    // An empty output stage never blocks input
    `ASSERT_IMP(a_ready_empty, aclk, aresetn, !m_valid, s_ready)

    // A result without a frame carries zero fields
    `ASSERT_IMP(a_zero_fields, aclk, aresetn, m_valid && !m_frame_found,
        m_length_byte == 8'd0 && m_frame_count == 32'd0 && m_payload_low == 64'd0
        && m_payload_high == 32'd0 && m_checksum_byte == 8'd0)

endmodule

bind sync_checksum_frame_deframer scfd_checker u_scfd_checker (.*);

FILE: tb/sv/frame_deframer_checker.sv
// Frame deframer checker: predicts each result from the accepted bytes and compares.
`timescale 1ns / 1ps
module frame_deframer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_frame_found,
    input  logic [7:0]                      m_length_byte,
    input  logic [31:0]                     m_frame_count,
    input  logic [63:0]                     m_payload_low,
    input  logic [31:0]                     m_payload_high,
    input  logic [7:0]                      m_checksum_byte,
    input  logic                            cfg_we,
    input  logic [scfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending_results
);

    // Frame layout: two sync bytes, summed span 2..18, checksum in the last slot.
    localparam int unsigned SUM_FIRST  = 2;
    localparam int unsigned SUM_LAST   = 18;
    localparam int unsigned CSUM_POS   = scfd_pkg::HELD_LEN;
    localparam int unsigned COUNT_POS  = 3;
    localparam int unsigned PAY_LO_POS = 7;
    localparam int unsigned PAY_HI_POS = 15;

    typedef struct packed {
        logic        found;
        logic [7:0]  length_byte;
        logic [31:0] frame_count;
        logic [63:0] payload_low;
        logic [31:0] payload_high;
        logic [7:0]  checksum_byte;
    } frame_result_t;

    logic [7:0]                  sync_first_q;
    logic [7:0]                  sync_second_q;
    logic [7:0]                  window [scfd_pkg::WIN_LEN];
    logic [scfd_pkg::FILL_W-1:0] fill;
    logic [7:0]                  window_sum;
    frame_result_t               expected_frames [$];

    // Shift one byte into the search window and work out the result it causes.
    function automatic frame_result_t deframe_byte(input logic [7:0] rx);
        frame_result_t res;
        int            pos;
        res = '0;
        pos = int'(fill);
        if (pos >= scfd_pkg::WIN_LEN) begin
            pos = scfd_pkg::WIN_LEN - 1;
        end
        window[pos] = rx;
        if (pos >= SUM_FIRST && pos <= SUM_LAST) begin
            window_sum = window_sum + rx;
        end
        fill = scfd_pkg::FILL_W'(pos + 1);
        if (fill == scfd_pkg::WIN_LEN) begin
            if (window[0] == sync_first_q && window[1] == sync_second_q &&
                window[CSUM_POS] == window_sum) begin
                res.found         = 1'b1;
                res.length_byte   = window[SUM_FIRST];
                for (int i = 0; i < 4; i++) begin
                    res.frame_count[8*i +: 8]  = window[COUNT_POS + i];
                    res.payload_high[8*i +: 8] = window[PAY_HI_POS + i];
                end
                for (int i = 0; i < 8; i++) begin
                    res.payload_low[8*i +: 8] = window[PAY_LO_POS + i];
                end
                res.checksum_byte = window[CSUM_POS];
                // Frame taken: empty the window, stale bytes get overwritten.
                fill       = '0;
                window_sum = '0;
            end else begin
                // No match: drop the oldest byte and slide the summed span by one.
                window_sum = window_sum - window[SUM_FIRST] + window[CSUM_POS];
                for (int i = 0; i < scfd_pkg::HELD_LEN; i++) begin
                    window[i] = window[i + 1];
                end
                window[CSUM_POS] = '0;
                fill             = scfd_pkg::FILL_W'(scfd_pkg::HELD_LEN);
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t exp_res;
        if (!aresetn) begin
            sync_first_q  = scfd_pkg::SYNC_FIRST_RST;
            sync_second_q = scfd_pkg::SYNC_SECOND_RST;
            for (int i = 0; i < scfd_pkg::WIN_LEN; i++) begin
                window[i] = '0;
            end
            fill       = '0;
            window_sum = '0;
            expected_frames.delete();
        end else begin
            // Register writes; unknown indexes are ignored.
            if (cfg_we) begin
                case (cfg_index)
                    scfd_pkg::REG_SYNC_FIRST:  sync_first_q  = cfg_wdata[7:0];
                    scfd_pkg::REG_SYNC_SECOND: sync_second_q = cfg_wdata[7:0];
                    default: ;
                endcase
            end

            // Compare each result transaction against the oldest prediction.
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none, actual found %b",
                             $time, m_frame_found);
                    fail_count++;
                end else begin
                    exp_res = expected_frames.pop_front();
                    check_field("frame_found", 64'(exp_res.found), 64'(m_frame_found));
                    check_field("length_byte", 64'(exp_res.length_byte),
                                64'(m_length_byte));
                    check_field("frame_count", 64'(exp_res.frame_count),
                                64'(m_frame_count));
                    check_field("payload_low", exp_res.payload_low, m_payload_low);
                    check_field("payload_high", 64'(exp_res.payload_high),
                                64'(m_payload_high));
                    check_field("checksum_byte", 64'(exp_res.checksum_byte),
                                64'(m_checksum_byte));
                end
            end

            // Predict the result of each accepted byte.
            if (s_valid && s_ready) begin
                expected_frames.push_back(deframe_byte(s_rx_byte));
            end
        end
        pending_results <= expected_frames.size();
    end

endmodule

FILE: tb/sv/sync_checksum_frame_deframer_tb.sv
// Testbench top of the frame deframer: byte stimulus, register phases and verdict.
`timescale 1ns / 1ps
module sync_checksum_frame_deframer_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_BYTES  = 85;
    localparam int BODY_LEN     = 17;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_rx_byte = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic                            m_frame_found;
    logic [7:0]                      m_length_byte;
    logic [31:0]                     m_frame_count;
    logic [63:0]                     m_payload_low;
    logic [31:0]                     m_payload_high;
    logic [7:0]                      m_checksum_byte;
    logic                            cfg_we    = 1'b0;
    logic [scfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int         fail_count;
    int         pending_results;
    int         cycle_count;
    logic [7:0] rx_stream [$];
    logic [7:0] frame_body [BODY_LEN];
    bit         src_quiet  = 1'b0;
    bit         sink_quiet = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sync_checksum_frame_deframer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_found   (m_frame_found),
        .m_length_byte   (m_length_byte),
        .m_frame_count   (m_frame_count),
        .m_payload_low   (m_payload_low),
        .m_payload_high  (m_payload_high),
        .m_checksum_byte (m_checksum_byte),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    frame_deframer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_found   (m_frame_found),
        .m_length_byte   (m_length_byte),
        .m_frame_count   (m_frame_count),
        .m_payload_low   (m_payload_low),
        .m_payload_high  (m_payload_high),
        .m_checksum_byte (m_checksum_byte),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Append sync bytes, the current body and its checksum, optionally corrupted.
    task automatic append_frame(input logic [7:0] sync_a, input logic [7:0] sync_b,
                                input logic [7:0] csum_flip);
        logic [7:0] body_sum;
        body_sum = '0;
        rx_stream.push_back(sync_a);
        rx_stream.push_back(sync_b);
        for (int i = 0; i < BODY_LEN; i++) begin
            rx_stream.push_back(frame_body[i]);
            body_sum = body_sum + frame_body[i];
        end
        rx_stream.push_back(body_sum ^ csum_flip);
    endtask

    // Bytes that tend to start a false sync search.
    function automatic logic [7:0] noise_byte(input logic [7:0] sync_a);
        return ($urandom_range(0, 3) == 0) ? sync_a : 8'($urandom_range(0, 255));
    endfunction

    // Build mostly good frames with random content, plus broken frames and noise.
    task automatic random_frames(input logic [7:0] sync_a, input logic [7:0] sync_b);
        int start;
        int kind;
        int pick;
        start = rx_stream.size();
        while (rx_stream.size() - start < PHASE_BYTES) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 4)) rx_stream.push_back(noise_byte(sync_a));
            end
            for (int i = 0; i < BODY_LEN; i++) begin
                pick = $urandom_range(0, 7);
                frame_body[i] = (pick == 0) ? 8'h00 :
                                (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            end
            case (kind)
                6: append_frame(sync_a, sync_b, 8'($urandom_range(1, 255)));
                7: append_frame(sync_a ^ 8'($urandom_range(1, 255)), sync_b, 8'h00);
                8: append_frame(sync_a, sync_b ^ 8'($urandom_range(1, 255)), 8'h00);
                9: repeat ($urandom_range(1, 30)) rx_stream.push_back(noise_byte(sync_a));
                default: append_frame(sync_a, sync_b, 8'h00);
            endcase
        end
    endtask

    // Drive one byte transaction after a random gap; keep valid up when no gap.
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            src_quiet = !src_quiet;
        end
        gap = src_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_stream();
        while (rx_stream.size() > 0) begin
            send_byte(rx_stream.pop_front());
        end
        s_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both sync registers, then an index past the list that must be ignored.
    task automatic program_syncs(input logic [7:0] sync_a, input logic [7:0] sync_b);
        cfg_we    <= 1'b1;
        cfg_index <= scfd_pkg::REG_SYNC_FIRST;
        cfg_wdata <= sync_a;
        @(posedge aclk);
        cfg_index <= scfd_pkg::REG_SYNC_SECOND;
        cfg_wdata <= sync_b;
        @(posedge aclk);
        cfg_index <= scfd_pkg::CFG_IDX_W'($urandom_range(2 ** scfd_pkg::CFG_IDX_W - 1,
                                                         scfd_pkg::REG_SYNC_SECOND + 1));
        cfg_wdata <= scfd_pkg::CFG_DATA_W'($urandom_range(0, 255));
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: stall a random number of cycles before each transaction.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                sink_quiet = !sink_quiet;
            end
            stall = sink_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [7:0] sync_a;
        logic [7:0] sync_b;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, then a frame with all-ones count and a
        // checksum that wraps to zero, then a fresh sync pair after the clear.
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        for (int i = 0; i < BODY_LEN; i++) begin
            frame_body[i] = (i < 5) ? 8'hFF : 8'h00;
        end
        frame_body[BODY_LEN - 1] = 8'h05;
        append_frame(scfd_pkg::SYNC_FIRST_RST, scfd_pkg::SYNC_SECOND_RST, 8'h00);
        rx_stream.push_back(scfd_pkg::SYNC_FIRST_RST);
        rx_stream.push_back(scfd_pkg::SYNC_SECOND_RST);
        random_frames(scfd_pkg::SYNC_FIRST_RST, scfd_pkg::SYNC_SECOND_RST);
        send_stream();
        wait_results_drained();

        // Register phases: extremes, random, equal sync bytes, back to reset values.
        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: begin sync_a = 8'h00; sync_b = 8'hFF; end
                2: begin sync_a = 8'hFF; sync_b = 8'h00; end
                3: begin
                    sync_a = 8'($urandom_range(0, 255));
                    sync_b = 8'($urandom_range(0, 255));
                end
                4: begin sync_a = 8'($urandom_range(0, 255)); sync_b = sync_a; end
                default: begin
                    sync_a = scfd_pkg::SYNC_FIRST_RST;
                    sync_b = scfd_pkg::SYNC_SECOND_RST;
                end
            endcase
            program_syncs(sync_a, sync_b);
            random_frames(sync_a, sync_b);
            send_stream();
            wait_results_drained();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
